[hdl/pqs_pkg.sv]
// Shared types and codes of the two-priority packet queue with load shedding.
package pqs_pkg;

  // Fixed field widths
  localparam int TAG_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int PBYTES_W = 16;
  localparam int MTYPE_W  = 8;
  localparam int STATUS_W = 3;
  localparam int PCNT_W   = 12;
  localparam int BYTE_W   = 33;
  localparam int MAXP_W   = 10;
  localparam int MAXB_W   = 32;
  localparam int MASK_W   = 64;
  localparam int CFG_IDX_W = 3;

  // Command kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PUSH_HIGH = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_LOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MASK_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MASK_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MASK_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MASK_3 = 3'd5;

  // One command transaction
  typedef struct packed {
    logic                kind;
    logic [TAG_W-1:0]    sender_tag;
    logic [HANDLE_W-1:0] packet_handle;
    logic [PBYTES_W-1:0] packet_bytes;
    logic [MTYPE_W-1:0]  message_type;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_sender_tag;
    logic [HANDLE_W-1:0] out_handle;
    logic [PBYTES_W-1:0] out_bytes;
    logic                low_flushed;
    logic                high_flushed;
    logic [PCNT_W-1:0]   packet_count;
    logic [BYTE_W-1:0]   byte_count;
  } result_t;

  // Stored descriptor
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [PBYTES_W-1:0] bytes;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

[hdl/two_priority_packet_queue_shed.sv]
// Top level: two-priority packet descriptor queue with load shedding.
//
// One command (push or pop) is taken in every clock cycle; start is honored whenever
// busy is low, and busy is high only while rst is asserted. Each command gives one
// result, strobed by result_valid for a single cycle. The receiver cannot hold results
// off, so results leave in command order at the command rate. The pipeline is an
// input register, one pass of queue and limit logic that also issues the descriptor
// RAM read, and an output register that picks up the popped descriptor from the RAM's
// registered read port. A pop's byte count leaves the queue totals in the cycle after
// the pop, once the RAM read returns, and is forwarded into the next command's limit
// check. The RAMs need no clearing pass after reset. Configuration writes are taken
// in any cycle outside reset but must only be issued while no command is in flight.
module two_priority_packet_queue_shed #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  pqs_pkg::cmd_t                   cmd,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pqs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pqs_pkg::MASK_W-1:0]      cfg_data,
  output logic                            result_valid,
  output pqs_pkg::result_t                result
);
  import pqs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int PK_W  = (CNT_W + 1 > MAXP_W) ? CNT_W + 1 : MAXP_W;
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  // head + offset modulo the depth; the sum stays below twice the depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] h,
                                                input logic [CNT_W-1:0] c);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(c);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[PTR_W-1:0];
  endfunction

  // configuration registers
  logic [MAXP_W-1:0]     max_packets;
  logic [MAXB_W-1:0]     max_bytes;
  logic [4*MASK_W-1:0]   prio_mask;

  // input register
  logic                  s0_valid;
  cmd_t                  s0_cmd;

  // middle stage: result control waiting for RAM data
  logic                  s1_valid;
  logic [STATUS_W-1:0]   s1_status;
  logic                  s1_lf;
  logic                  s1_hf;
  logic                  s1_pop_high;
  logic                  s1_pop_low;

  // queue state
  logic [PTR_W-1:0]      high_head, high_head_next;
  logic [CNT_W-1:0]      high_count, high_count_next;
  logic [PTR_W-1:0]      low_head, low_head_next;
  logic [CNT_W-1:0]      low_count, low_count_next;
  logic [BYTE_W-1:0]     high_bytes, high_bytes_next;
  logic [BYTE_W-1:0]     low_bytes, low_bytes_next;

  // RAM ports
  logic                  we_high, we_low, re_high, re_low;
  logic [PTR_W-1:0]      waddr_high, waddr_low;
  entry_t                wentry, rd_high, rd_low;

  // single-pass logic
  logic [BYTE_W-1:0]     high_eff, low_eff;
  logic [BYTE_W:0]       tot_eff;
  logic [PK_W-1:0]       pk_sum;
  logic                  is_high, over1, over2, hflush;
  logic [CNT_W-1:0]      low_count_sh;
  logic [BYTE_W-1:0]     low_eff_sh;
  logic [STATUS_W-1:0]   status_d;
  logic                  lf_d, hf_d;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packets <= '1;
      max_bytes   <= '1;
      prio_mask   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_PACKETS: max_packets <= cfg_data[MAXP_W-1:0];
        REG_MAX_BYTES:   max_bytes   <= cfg_data[MAXB_W-1:0];
        REG_PRIO_MASK_0: prio_mask[0*MASK_W +: MASK_W] <= cfg_data;
        REG_PRIO_MASK_1: prio_mask[1*MASK_W +: MASK_W] <= cfg_data;
        REG_PRIO_MASK_2: prio_mask[2*MASK_W +: MASK_W] <= cfg_data;
        REG_PRIO_MASK_3: prio_mask[3*MASK_W +: MASK_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    if (start && !busy) begin
      s0_cmd <= cmd;
    end
  end

  // totals with last cycle's pop folded in
  assign high_eff = high_bytes - (s1_pop_high ? BYTE_W'(rd_high.bytes) : '0);
  assign low_eff  = low_bytes  - (s1_pop_low  ? BYTE_W'(rd_low.bytes)  : '0);
  assign tot_eff  = {1'b0, high_eff} + {1'b0, low_eff};
  assign pk_sum   = PK_W'(high_count) + PK_W'(low_count);

  // limit checks: the second one only matters once the low queue is shed
  assign is_high = prio_mask[s0_cmd.message_type];
  assign over1   = (pk_sum > PK_W'(max_packets)) || (tot_eff > (BYTE_W + 1)'(max_bytes));
  assign over2   = over1 && ((PK_W'(high_count) > PK_W'(max_packets)) ||
                             (high_eff > BYTE_W'(max_bytes)));
  assign hflush  = over2 || (high_count >= DEPTH_C);
  assign low_count_sh = over1 ? '0 : low_count;
  assign low_eff_sh   = over1 ? '0 : low_eff;

  assign wentry = '{tag: s0_cmd.sender_tag, bytes: s0_cmd.packet_bytes,
                    handle: s0_cmd.packet_handle};

  // next queue state and RAM requests
  always_comb begin
    high_head_next  = high_head;
    high_count_next = high_count;
    high_bytes_next = high_eff;
    low_head_next   = low_head;
    low_count_next  = low_count;
    low_bytes_next  = low_eff;
    we_high    = 1'b0;
    we_low     = 1'b0;
    re_high    = 1'b0;
    re_low     = 1'b0;
    waddr_high = wrap_add(high_head, high_count);
    waddr_low  = wrap_add(low_head, low_count);
    status_d   = ST_POP_EMPTY;
    lf_d       = 1'b0;
    hf_d       = 1'b0;
    if (s0_valid) begin
      if (s0_cmd.kind == KIND_PUSH) begin
        lf_d = over1;
        if (over1) begin
          low_head_next  = '0;
          low_count_next = '0;
          low_bytes_next = '0;
        end
        if (over2 && !is_high) begin
          status_d = ST_DROPPED;
        end else if (is_high) begin
          hf_d    = hflush;
          we_high = 1'b1;
          if (hflush) begin
            waddr_high     = '0;
            high_head_next = '0;
          end
          high_count_next = (hflush ? '0 : high_count) + 1'b1;
          high_bytes_next = (hflush ? '0 : high_eff) + BYTE_W'(s0_cmd.packet_bytes);
          status_d = ST_PUSH_HIGH;
        end else if (low_count_sh >= DEPTH_C) begin
          status_d = ST_DROPPED;
        end else begin
          we_low = 1'b1;
          if (over1) begin
            waddr_low = '0;
          end
          low_count_next = low_count_sh + 1'b1;
          low_bytes_next = low_eff_sh + BYTE_W'(s0_cmd.packet_bytes);
          status_d = ST_PUSH_LOW;
        end
      end else begin
        // pop: high queue first
        if (high_count != '0) begin
          re_high         = 1'b1;
          high_head_next  = (high_head == LAST_PTR) ? '0 : high_head + 1'b1;
          high_count_next = high_count - 1'b1;
          status_d        = ST_POPPED;
        end else if (low_count != '0) begin
          re_low         = 1'b1;
          low_head_next  = (low_head == LAST_PTR) ? '0 : low_head + 1'b1;
          low_count_next = low_count - 1'b1;
          status_d       = ST_POPPED;
        end
      end
    end
  end

  // queue state and middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      high_head   <= '0;
      high_count  <= '0;
      high_bytes  <= '0;
      low_head    <= '0;
      low_count   <= '0;
      low_bytes   <= '0;
      s1_valid    <= 1'b0;
      s1_pop_high <= 1'b0;
      s1_pop_low  <= 1'b0;
    end else begin
      high_head   <= high_head_next;
      high_count  <= high_count_next;
      high_bytes  <= high_bytes_next;
      low_head    <= low_head_next;
      low_count   <= low_count_next;
      low_bytes   <= low_bytes_next;
      s1_valid    <= s0_valid;
      s1_pop_high <= re_high;
      s1_pop_low  <= re_low;
    end
    s1_status <= status_d;
    s1_lf     <= lf_d;
    s1_hf     <= hf_d;
  end

  pqs_store #(.DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_high_store (
    .clk   (clk),
    .we    (we_high),
    .waddr (waddr_high),
    .wdata (wentry),
    .re    (re_high),
    .raddr (high_head),
    .rdata (rd_high)
  );

  pqs_store #(.DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_low_store (
    .clk   (clk),
    .we    (we_low),
    .waddr (waddr_low),
    .wdata (wentry),
    .re    (re_low),
    .raddr (low_head),
    .rdata (rd_low)
  );

  // output register; totals now include the middle stage's pop
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s1_valid;
    end
    result.status       <= s1_status;
    result.low_flushed  <= s1_lf;
    result.high_flushed <= s1_hf;
    result.packet_count <= PCNT_W'(pk_sum);
    result.byte_count   <= tot_eff[BYTE_W-1:0];
    if (s1_pop_high) begin
      result.out_sender_tag <= rd_high.tag;
      result.out_handle     <= rd_high.handle;
      result.out_bytes      <= rd_high.bytes;
    end else if (s1_pop_low) begin
      result.out_sender_tag <= rd_low.tag;
      result.out_handle     <= rd_low.handle;
      result.out_bytes      <= rd_low.bytes;
    end else begin
      result.out_sender_tag <= '0;
      result.out_handle     <= '0;
      result.out_bytes      <= '0;
    end
  end

endmodule

[hdl/pqs_store.sv]
// Descriptor RAM of one queue: one write port, one registered read port.
module pqs_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  pqs_pkg::entry_t   wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output pqs_pkg::entry_t   rdata
);
  import pqs_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/pqs_checker.sv]
// Port-level assertions for the packet queue, bound to the top level.
module pqs_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input pqs_pkg::result_t result
);
  import pqs_pkg::*;

  // every accepted command gives a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 result_valid)
    else $error("accepted command gave no result");

  // no result without an earlier accepted command
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 3))
    else $error("result without a command");

  // only a successful pop carries a descriptor
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_POPPED |->
      result.out_sender_tag == '0 && result.out_handle == '0 && result.out_bytes == '0)
    else $error("descriptor fields set on a non-pop result");

  // pops never shed
  a_pop_no_flush: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_POPPED || result.status == ST_POP_EMPTY) |->
      !result.low_flushed && !result.high_flushed)
    else $error("flush flag on a pop");

  // an empty pop means both queues hold nothing
  a_empty_totals: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_POP_EMPTY |->
      result.packet_count == '0 && result.byte_count == '0)
    else $error("empty pop with nonzero totals");

endmodule

bind two_priority_packet_queue_shed pqs_checker u_pqs_checker (.*);
